### design/cmac_pkg.sv
// ----------------------------------------------------------------------------
// cmac_pkg: shared types and constants for the current monitor core
// Operation codes, widths, defaults and the milliamp saturation function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmac_pkg;

   localparam int CAPTURE_DEPTH_DEF = 512;
   localparam int AVG_DEPTH_DEF     = 10;

   localparam int SAMPLE_W     = 12;
   localparam int SCALE_W      = 24;
   localparam int MA_W         = 16;
   localparam int READ_INDEX_W = 9;
   localparam int FILL_OUT_W   = 9;
   localparam int PROD_W       = SAMPLE_W + SCALE_W;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd52813;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_START  = 2'd1,
      OP_READ   = 2'd2,
      OP_IDLE   = 2'd3
   } op_type;

   // capture memory port controls for one transaction
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } cap_ctl_type;

   // (count * scale) >> 16, saturated to 16 bits
   function automatic logic [MA_W-1:0] sat_ma(input logic [PROD_W-1:0] prod);
      logic [PROD_W-17:0] shifted;
      shifted = prod[PROD_W-1:16];
      if (|shifted[PROD_W-17:MA_W]) begin
         return {MA_W{1'b1}};
      end
      return shifted[MA_W-1:0];
   endfunction

endpackage

### design/cmac_capture_mem.sv
// ----------------------------------------------------------------------------
// cmac_capture_mem: capture buffer
// Single write port and registered read port; read data reads zero when
// no read was requested.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmac_capture_mem
   import cmac_pkg::*;
#(
   parameter int DEPTH = CAPTURE_DEPTH_DEF,
   parameter int AW    = $clog2(CAPTURE_DEPTH_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  cap_ctl_type       ctl,
   input  logic [AW-1:0]     wr_addr,
   input  logic [PROD_W-1:0] wr_prod,
   input  logic [AW-1:0]     rd_addr,
   output logic [MA_W-1:0]   rd_data
);

   logic [MA_W-1:0] mem [DEPTH];
   logic [MA_W-1:0] rd_raw_ff;
   logic            rd_sel_ff;

   always_ff @(posedge clock) begin
      if (en && ctl.wr_en) begin
         mem[wr_addr] <= sat_ma(wr_prod);
      end
      if (en && ctl.rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_sel_ff <= 1'b0;
      end else if (en) begin
         rd_sel_ff <= ctl.rd_en;
      end
   end

   assign rd_data = rd_sel_ff ? rd_raw_ff : '0;

endmodule

### design/current_monitor_average_capture_core.sv
// ----------------------------------------------------------------------------
// current_monitor_average_capture_core: two-channel current averager with capture
// Path: a transaction passes stage 1, stage 2, stage 3 and then the output register.
// Throughput: one transaction per cycle; the pipeline holds as one while the
//   output register is stalled.
// Reset: rings read as zero until first written (wrap flag), no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module current_monitor_average_capture_core
   import cmac_pkg::*;
#(
   parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF,
   parameter int AVG_DEPTH     = AVG_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_wr_en,
   input  logic [SCALE_W-1:0]      csr_wr_data,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_operation,
   input  logic [SAMPLE_W-1:0]     req_sample_int,
   input  logic [SAMPLE_W-1:0]     req_sample_ext,
   input  logic [READ_INDEX_W-1:0] req_read_index,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [MA_W-1:0]         rsp_avg_int_ma,
   output logic [MA_W-1:0]         rsp_avg_ext_ma,
   output logic                    rsp_capture_active,
   output logic [FILL_OUT_W-1:0]   rsp_capture_fill,
   output logic [MA_W-1:0]         rsp_read_data
);

   // --- derived sizes -------------------------------------------------------
   localparam int CW     = $clog2(CAPTURE_DEPTH);          // capture address
   localparam int IW     = (CW > READ_INDEX_W) ? CW : READ_INDEX_W;
   localparam int FW     = (CW > FILL_OUT_W) ? CW : FILL_OUT_W;
   localparam int RPW    = $clog2(AVG_DEPTH);              // ring position
   localparam int SUM_W  = SAMPLE_W + RPW;                 // holds 4095 * depth
   localparam int RING_W = 2 * SAMPLE_W;                   // {int, ext}

   // sum / AVG_DEPTH by reciprocal: exact for every SUM_W-bit sum
   localparam int          DIV_SH  = SUM_W + RPW;
   localparam int unsigned DIV_MUL = ((1 << DIV_SH) + AVG_DEPTH - 1) / AVG_DEPTH;
   localparam int          MUL_W   = SUM_W + 1;
   localparam int          QP_W    = SUM_W + MUL_W;

   localparam logic [MUL_W-1:0] DIV_MUL_C = MUL_W'(DIV_MUL);

   // --- handshake -----------------------------------------------------------
   // Whole pipeline moves together; it only halts when the output
   // register is full and stalled.
   logic adv;
   logic accept;
   logic rsp_valid_ff;
   op_type req_op;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign req_op    = op_type'(req_operation);

   // --- scale register ------------------------------------------------------
   logic [SCALE_W-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // --- capture arm state, resolved at acceptance ---------------------------
   logic          armed_ff, armed_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          cap_we0;

   always_comb begin
      armed_in = armed_ff;
      fill_in  = fill_ff;
      cap_we0  = 1'b0;
      if (accept) begin
         case (req_op)
            OP_SAMPLE: begin
               if (armed_ff) begin
                  cap_we0 = 1'b1;
                  if (fill_ff == CW'(CAPTURE_DEPTH - 1)) begin
                     armed_in = 1'b0;
                     fill_in  = '0;
                  end else begin
                     fill_in = fill_ff + CW'(1);
                  end
               end
            end
            OP_START: begin
               armed_in = 1'b1;
               fill_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         fill_ff  <= '0;
      end else begin
         armed_ff <= armed_in;
         fill_ff  <= fill_in;
      end
   end

   // --- ring memory: position and wrap flag ---------------------------------
   // Entries are written in position order, so before the first wrap the
   // entry about to be replaced has never been written and counts as zero.
   logic [RING_W-1:0] ring_mem [AVG_DEPTH];
   logic [RPW-1:0]    ring_pos_ff, ring_pos_in;
   logic              wrapped_ff, wrapped_in;

   always_comb begin
      ring_pos_in = ring_pos_ff;
      wrapped_in  = wrapped_ff;
      if (accept && req_op == OP_SAMPLE) begin
         if (ring_pos_ff == RPW'(AVG_DEPTH - 1)) begin
            ring_pos_in = '0;
            wrapped_in  = 1'b1;
         end else begin
            ring_pos_in = ring_pos_ff + RPW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_pos_ff <= '0;
         wrapped_ff  <= 1'b0;
      end else begin
         ring_pos_ff <= ring_pos_in;
         wrapped_ff  <= wrapped_in;
      end
   end

   // --- stage 1: transaction registered, old ring entry read ----------------
   logic                    v1_ff;
   op_type                  op1_ff;
   logic [SAMPLE_W-1:0]     si1_ff, se1_ff;
   logic [READ_INDEX_W-1:0] ri1_ff;
   logic [RPW-1:0]          rpos1_ff;
   logic                    old_ok1_ff;
   logic [RING_W-1:0]       ring_rd_ff;
   logic                    cap_we1_ff;
   logic [CW-1:0]           cap_addr1_ff;
   logic                    act1_ff;
   logic [CW-1:0]           fill1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff       <= req_op;
         si1_ff       <= req_sample_int;
         se1_ff       <= req_sample_ext;
         ri1_ff       <= req_read_index;
         rpos1_ff     <= ring_pos_ff;
         old_ok1_ff   <= wrapped_ff;
         ring_rd_ff   <= ring_mem[ring_pos_ff];
         cap_we1_ff   <= cap_we0;
         cap_addr1_ff <= fill_ff;
         act1_ff      <= armed_in;
         fill1_ff     <= fill_in;
      end
   end

   // --- running sums, updated as a sample leaves stage 1 --------------------
   // The next sample always addresses a different ring entry, so the
   // stage-1 write never collides with the acceptance read.
   logic [SUM_W-1:0]    sum_int_ff, sum_int_in;
   logic [SUM_W-1:0]    sum_ext_ff, sum_ext_in;
   logic [SAMPLE_W-1:0] old_int, old_ext;
   logic                ring_upd;

   assign ring_upd = adv && v1_ff && op1_ff == OP_SAMPLE;
   assign old_int  = old_ok1_ff ? ring_rd_ff[RING_W-1:SAMPLE_W] : '0;
   assign old_ext  = old_ok1_ff ? ring_rd_ff[SAMPLE_W-1:0] : '0;

   always_comb begin
      sum_int_in = sum_int_ff;
      sum_ext_in = sum_ext_ff;
      if (ring_upd) begin
         sum_int_in = sum_int_ff - SUM_W'(old_int) + SUM_W'(si1_ff);
         sum_ext_in = sum_ext_ff - SUM_W'(old_ext) + SUM_W'(se1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_int_ff <= '0;
         sum_ext_ff <= '0;
      end else begin
         sum_int_ff <= sum_int_in;
         sum_ext_ff <= sum_ext_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_upd) begin
         ring_mem[rpos1_ff] <= {si1_ff, se1_ff};
      end
   end

   // --- stage 2: sums snapshot, capture product, read index check -----------
   logic [IW-1:0]     ri_wide;
   logic              ri_ok;
   logic              v2_ff;
   logic [SUM_W-1:0]  sum2_int_ff, sum2_ext_ff;
   logic [PROD_W-1:0] cap_prod2_ff;
   logic              cap_we2_ff;
   logic [CW-1:0]     cap_addr2_ff;
   logic              rd_en2_ff;
   logic [CW-1:0]     rd_addr2_ff;
   logic              act2_ff;
   logic [CW-1:0]     fill2_ff;

   // one spare bit so that a depth of a full power of two compares correctly
   assign ri_wide = IW'(ri1_ff);
   assign ri_ok   = {1'b0, ri_wide} < (IW + 1)'(CAPTURE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum2_int_ff  <= sum_int_in;
         sum2_ext_ff  <= sum_ext_in;
         cap_prod2_ff <= PROD_W'(si1_ff) * PROD_W'(scale_ff);
         cap_we2_ff   <= v1_ff && cap_we1_ff;
         cap_addr2_ff <= cap_addr1_ff;
         rd_en2_ff    <= v1_ff && op1_ff == OP_READ && ri_ok;
         rd_addr2_ff  <= ri_wide[CW-1:0];
         act2_ff      <= act1_ff;
         fill2_ff     <= fill1_ff;
      end
   end

   // --- capture memory: written and read as transactions leave stage 2 ------
   // Write and read sit in the same stage, so a read always sees every
   // earlier capture write.
   cap_ctl_type     cap_ctl;
   logic [MA_W-1:0] cap_rd_data;

   assign cap_ctl.wr_en = cap_we2_ff;
   assign cap_ctl.rd_en = rd_en2_ff;

   cmac_capture_mem #(
      .DEPTH (CAPTURE_DEPTH),
      .AW    (CW)
   ) u_capture (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .ctl     (cap_ctl),
      .wr_addr (cap_addr2_ff),
      .wr_prod (cap_prod2_ff),
      .rd_addr (rd_addr2_ff),
      .rd_data (cap_rd_data)
   );

   // --- stage 3: divide by depth through the reciprocal ---------------------
   logic [QP_W-1:0]     qp_int, qp_ext;
   logic                v3_ff;
   logic [SAMPLE_W-1:0] q3_int_ff, q3_ext_ff;
   logic                act3_ff;
   logic [CW-1:0]       fill3_ff;

   assign qp_int = QP_W'(sum2_int_ff) * QP_W'(DIV_MUL_C);
   assign qp_ext = QP_W'(sum2_ext_ff) * QP_W'(DIV_MUL_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q3_int_ff <= qp_int[DIV_SH +: SAMPLE_W];
         q3_ext_ff <= qp_ext[DIV_SH +: SAMPLE_W];
         act3_ff   <= act2_ff;
         fill3_ff  <= fill2_ff;
      end
   end

   // --- output register: scale to milliamps ---------------------------------
   logic [PROD_W-1:0]     ma_prod_int, ma_prod_ext;
   logic [FW-1:0]         fill_wide;
   logic [MA_W-1:0]       avg_int_ff, avg_ext_ff, rd_data_ff;
   logic                  act_ff;
   logic [FILL_OUT_W-1:0] fill_out_ff;

   assign ma_prod_int = PROD_W'(q3_int_ff) * PROD_W'(scale_ff);
   assign ma_prod_ext = PROD_W'(q3_ext_ff) * PROD_W'(scale_ff);
   assign fill_wide   = FW'(fill3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         avg_int_ff  <= sat_ma(ma_prod_int);
         avg_ext_ff  <= sat_ma(ma_prod_ext);
         act_ff      <= act3_ff;
         fill_out_ff <= fill_wide[FILL_OUT_W-1:0];
         rd_data_ff  <= cap_rd_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_avg_int_ma     = avg_int_ff;
   assign rsp_avg_ext_ma     = avg_ext_ff;
   assign rsp_capture_active = act_ff;
   assign rsp_capture_fill   = fill_out_ff;
   assign rsp_read_data      = rd_data_ff;

   // --- assertions ----------------------------------------------------------
   a_idle_fill_zero : assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> fill_ff == '0)
      else $error("capture fill position non-zero while disarmed");

   a_rsp_fill_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_capture_active |-> rsp_capture_fill == '0)
      else $error("transaction reports fill position without an active capture");

   a_ring_pos_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, ring_pos_ff} < (RPW + 1)'(AVG_DEPTH))
      else $error("ring position beyond averaging depth");

   a_sum_bound : assert property (@(posedge clock) disable iff (reset)
      sum_int_ff <= SUM_W'(4095 * AVG_DEPTH) && sum_ext_ff <= SUM_W'(4095 * AVG_DEPTH))
      else $error("running sum exceeds depth times full scale");

   a_read_gated : assert property (@(posedge clock) disable iff (reset)
      $past(adv) && !$past(rd_en2_ff) |-> cap_rd_data == '0)
      else $error("capture read data not zero without a read");

endmodule
